>>> rtl/mf5x5_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf5x5_pkg
// Shared types and constants of the streaming 5x5 median filter.
// ----------------------------------------------------------------------------
package mf5x5_pkg;

    localparam int PIX_W      = 8;
    localparam int COORD_W    = 10;
    localparam int DIM_W      = 11;
    localparam int PEND_W     = 12;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MIN_DIM    = 5;
    localparam int LB_ADDR_W  = 10;
    localparam int LANES      = 4;
    localparam int WIN_N      = 5;
    localparam int WIN_SIZE   = 25;
    localparam int WIN_MID    = 12;
    localparam int RANK_W     = 5;
    localparam int GRP_W      = 3;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;
    localparam int QCNT_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1
    } t_cfg_idx;

    typedef struct packed {
        t_op              operation;
        logic [PIX_W-1:0] pixel_in;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel_out;
        logic [COORD_W-1:0] out_row;
        logic [COORD_W-1:0] out_col;
        logic               frame_last;
    } t_out_item;

    typedef logic [WIN_SIZE-1:0][PIX_W-1:0] t_win;

    typedef struct packed {
        logic               interior;
        logic [PIX_W-1:0]   sample;
        t_win               win;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last;
    } t_job;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              empty;
    } t_q_status;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        if (v < DIM_W'(MIN_DIM)) begin
            return DIM_W'(MIN_DIM);
        end else if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

endpackage

>>> rtl/mf5x5_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf5x5_front
// Takes words, tracks raster positions, keeps the line store and the 5x5
// window, and issues one job per result into the job queue.
// ----------------------------------------------------------------------------
module mf5x5_front import mf5x5_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_q_status             i_q_stat,
    output logic                  o_job_push,
    output t_job                  o_job
);

    // line store word: lane j holds the sample j rows above the one written
    logic [LANES*PIX_W-1:0] lbuf [MAX_WIDTH];

    logic [DIM_W-1:0]   r_width, r_height, n_width, n_height;
    logic [COORD_W-1:0] r_in_row, r_in_col, r_out_row, r_out_col;
    logic [COORD_W-1:0] n_in_row, n_in_col, n_out_row, n_out_col;
    logic [PEND_W-1:0]  r_pending, n_pending;
    logic               r_jb_valid, n_jb_valid;

    logic [LANES*PIX_W-1:0]              r_lb_rd, r_lb_tap;
    logic [WIN_N-1:0][WIN_N-1:0][PIX_W-1:0] r_win;
    logic               r_jb_border;
    logic [1:0]         r_jb_lane;
    logic [COORD_W-1:0] r_jb_row, r_jb_col;
    logic               r_jb_last;

    logic               w_accept, w_pix, w_flush, w_cfg_hit, w_emit, w_border, w_last;
    logic [QCNT_W:0]    w_used;
    logic [DIM_W-1:0]   w_in_col_inc, w_in_row_inc, w_out_col_inc, w_out_row_inc;
    logic [PEND_W-1:0]  w_lim, w_back;
    logic [1:0]         w_lane;
    logic [LB_ADDR_W-1:0] w_rd_addr;
    logic [WIN_N-1:0][PIX_W-1:0] w_col;

    // one slot is held back for the job still in the issue register
    assign w_used     = {1'b0, i_q_stat.count} + {{QCNT_W{1'b0}}, r_jb_valid};
    assign o_in_stall = w_used >= (QCNT_W+1)'(QDEPTH);

    assign w_accept  = i_in_valid && !o_in_stall;
    assign w_pix     = w_accept && (i_in_data.operation == OP_PIXEL);
    assign w_flush   = w_accept && (i_in_data.operation == OP_FLUSH);
    assign w_cfg_hit = i_cfg_wr_en && (i_cfg_idx == CFG_WIDTH || i_cfg_idx == CFG_HEIGHT);

    assign w_in_col_inc  = {1'b0, r_in_col} + DIM_W'(1);
    assign w_in_row_inc  = {1'b0, r_in_row} + DIM_W'(1);
    assign w_out_col_inc = {1'b0, r_out_col} + DIM_W'(1);
    assign w_out_row_inc = {1'b0, r_out_row} + DIM_W'(1);

    assign w_lim    = {r_width, 1'b0} + PEND_W'(2);
    assign w_border = (r_out_row < COORD_W'(2)) || (r_out_col < COORD_W'(2)) ||
                      (({1'b0, r_out_row} + DIM_W'(2)) >= r_height) ||
                      (({1'b0, r_out_col} + DIM_W'(2)) >= r_width);
    assign w_last   = (w_out_row_inc == r_height) && (w_out_col_inc == r_width);
    assign w_emit   = w_pix ? (r_pending >= w_lim)
                            : (w_flush && (r_pending != '0) && w_border);

    // distance, in samples, of the oldest pending sample from the newest one; w_lane turns it into rows
    assign w_back = w_pix ? r_pending : (r_pending - PEND_W'(1));
    always_comb begin
        if (w_back < {1'b0, r_width}) begin
            w_lane = 2'd0;
        end else if (w_back < {r_width, 1'b0}) begin
            w_lane = 2'd1;
        end else begin
            w_lane = 2'd2;
        end
    end

    always_comb begin
        n_width    = r_width;
        n_height   = r_height;
        n_in_row   = r_in_row;
        n_in_col   = r_in_col;
        n_out_row  = r_out_row;
        n_out_col  = r_out_col;
        n_pending  = r_pending;
        n_jb_valid = 1'b0;
        if (w_cfg_hit) begin
            if (i_cfg_idx == CFG_WIDTH) begin
                n_width = clamp_dim(i_cfg_data, DIM_W'(MAX_WIDTH));
            end else begin
                n_height = clamp_dim(i_cfg_data, DIM_W'(MAX_HEIGHT));
            end
            n_in_row  = '0;
            n_in_col  = '0;
            n_out_row = '0;
            n_out_col = '0;
            n_pending = '0;
        end else begin
            if (w_pix) begin
                if (w_in_col_inc >= r_width) begin
                    n_in_col = '0;
                    n_in_row = (w_in_row_inc >= r_height) ? '0 : w_in_row_inc[COORD_W-1:0];
                end else begin
                    n_in_col = w_in_col_inc[COORD_W-1:0];
                end
            end
            if (w_emit) begin
                if (w_out_col_inc >= r_width) begin
                    n_out_col = '0;
                    n_out_row = (w_out_row_inc >= r_height) ? '0
                                                            : w_out_row_inc[COORD_W-1:0];
                end else begin
                    n_out_col = w_out_col_inc[COORD_W-1:0];
                end
            end
            if (w_pix && !w_emit) begin
                n_pending = r_pending + PEND_W'(1);
            end else if (w_flush && w_emit) begin
                n_pending = r_pending - PEND_W'(1);
            end
            n_jb_valid = w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= DIM_W'(MAX_WIDTH);
            r_height   <= DIM_W'(MAX_HEIGHT);
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_pending  <= '0;
            r_jb_valid <= 1'b0;
        end else begin
            r_width    <= n_width;
            r_height   <= n_height;
            r_in_row   <= n_in_row;
            r_in_col   <= n_in_col;
            r_out_row  <= n_out_row;
            r_out_col  <= n_out_col;
            r_pending  <= n_pending;
            r_jb_valid <= n_jb_valid;
        end
    end

    // r_lb_rd always shows the word at the current column pointer
    assign w_rd_addr = (!i_rst_n || w_cfg_hit) ? '0 : (w_pix ? n_in_col : r_in_col);
    assign w_col     = {r_lb_rd, i_in_data.pixel_in};

    always_ff @(posedge i_clk) begin
        if (w_pix) begin
            lbuf[r_in_col] <= {r_lb_rd[(LANES-1)*PIX_W-1:0], i_in_data.pixel_in};
        end
        r_lb_rd  <= lbuf[w_rd_addr];
        r_lb_tap <= lbuf[r_out_col];
    end

    always_ff @(posedge i_clk) begin
        if (w_pix) begin
            for (int c = WIN_N - 1; c > 0; c--) begin
                r_win[c] <= r_win[c-1];
            end
            r_win[0] <= w_col;
        end
        if (w_accept) begin
            r_jb_border <= w_border;
            r_jb_lane   <= w_lane;
            r_jb_row    <= r_out_row;
            r_jb_col    <= r_out_col;
            r_jb_last   <= w_last;
        end
    end

    assign o_job_push    = r_jb_valid;
    assign o_job.interior = !r_jb_border;
    assign o_job.sample   = r_lb_tap[r_jb_lane*PIX_W +: PIX_W];
    assign o_job.win      = t_win'(r_win);
    assign o_job.row      = r_jb_row;
    assign o_job.col      = r_jb_col;
    assign o_job.last     = r_jb_last;

endmodule

>>> rtl/mf5x5_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf5x5_queue
// Small register queue of jobs between the front and the median back end.
// ----------------------------------------------------------------------------
module mf5x5_queue import mf5x5_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_job      i_job,
    input  logic      i_pop,
    output t_job      o_job,
    output t_q_status o_stat
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    assign o_job        = r_mem[r_rd_ptr];
    assign o_stat.count = r_count;
    assign o_stat.empty = (r_count == '0);

endmodule

>>> rtl/mf5x5_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf5x5_back
// Rank-based median of the 25 window samples: compare, count in two steps,
// select. Border jobs pass their own sample. Ends in the output register.
// ----------------------------------------------------------------------------
module mf5x5_back import mf5x5_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_status i_q_stat,
    input  t_job      i_job,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic w_en;
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_o_valid;
    t_job r_s1_job, r_s2_job, r_s3_job;
    logic [WIN_SIZE-1:0][WIN_SIZE-1:0] r_s1_lt, w_lt;
    logic [WIN_SIZE-1:0][WIN_N-1:0][GRP_W-1:0] r_s2_part, w_part;
    logic [WIN_SIZE-1:0][RANK_W-1:0] r_s3_rank, w_rank;
    logic [PIX_W-1:0] w_med;
    t_out_item r_out;

    assign w_en  = !r_o_valid || !i_out_stall;
    assign o_pop = w_en && !i_q_stat.empty;

    // lt[i][j]: sample j sorts before sample i (ties broken by position)
    always_comb begin
        for (int i = 0; i < WIN_SIZE; i++) begin
            for (int j = 0; j < WIN_SIZE; j++) begin
                w_lt[i][j] = (i_job.win[j] < i_job.win[i]) ||
                             ((i_job.win[j] == i_job.win[i]) && (j < i));
            end
        end
    end

    always_comb begin
        for (int i = 0; i < WIN_SIZE; i++) begin
            for (int g = 0; g < WIN_N; g++) begin
                w_part[i][g] = '0;
                for (int k = 0; k < WIN_N; k++) begin
                    w_part[i][g] = w_part[i][g] + GRP_W'(r_s1_lt[i][g*WIN_N + k]);
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < WIN_SIZE; i++) begin
            w_rank[i] = '0;
            for (int g = 0; g < WIN_N; g++) begin
                w_rank[i] = w_rank[i] + RANK_W'(r_s2_part[i][g]);
            end
        end
    end

    // exactly one sample has rank WIN_MID
    always_comb begin
        w_med = '0;
        for (int i = 0; i < WIN_SIZE; i++) begin
            if (r_s3_rank[i] == RANK_W'(WIN_MID)) begin
                w_med = w_med | r_s3_job.win[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= o_pop;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_o_valid  <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_job  <= i_job;
            r_s1_lt   <= w_lt;
            r_s2_job  <= r_s1_job;
            r_s2_part <= w_part;
            r_s3_job  <= r_s2_job;
            r_s3_rank <= w_rank;
            r_out.pixel_out  <= r_s3_job.interior ? w_med : r_s3_job.sample;
            r_out.out_row    <= r_s3_job.row;
            r_out.out_col    <= r_s3_job.col;
            r_out.frame_last <= r_s3_job.last;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_out;

endmodule

>>> rtl/median_filter_5x5.sv
`timescale 1ns / 1ps
// Path: a result word released by an accepted item passes the issue register,
//   queue, compare, two count stages and output register; stalls can hold it.
// Throughput: one word per cycle unless stalled; the single-port-write line store
//   and rank pipeline each take one word a cycle. Results trail pixels by 2*W+2.
// Reset: synchronous, active low; positions and pending count clear, width and
//   height return to 1024. The line store is not cleared and needs no pass.
// ----------------------------------------------------------------------------
// median_filter_5x5
// Streaming 5x5 median filter over raster-order grayscale frames.
// ----------------------------------------------------------------------------
module median_filter_5x5 import mf5x5_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic      w_push, w_pop;
    t_job      w_job_in, w_job_out;
    t_q_status w_q_stat;

    mf5x5_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_stat   (w_q_stat),
        .o_job_push (w_push),
        .o_job      (w_job_in)
    );

    mf5x5_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_job  (w_job_in),
        .i_pop  (w_pop),
        .o_job  (w_job_out),
        .o_stat (w_q_stat)
    );

    mf5x5_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_stat   (w_q_stat),
        .i_job      (w_job_out),
        .o_pop      (w_pop),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_stat.count <= QCNT_W'(QDEPTH))
        else $error("job queue over capacity");

    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_stat.count == QCNT_W'(QDEPTH)) |-> o_in_stall)
        else $error("input taken with job queue full");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("job queue popped while empty");

    a_full_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_q_stat.count == QCNT_W'(QDEPTH)) && !w_pop) |-> !w_push)
        else $error("job pushed into full queue");

endmodule

>>> test/mf5x5_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf5x5_checker
// Watches the pixel, result and register ports of the 5x5 median filter. It
// keeps its own sample history and output position, works out each released
// word, and compares the words that leave the filter against them in order.
// ----------------------------------------------------------------------------
module mf5x5_checker import mf5x5_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in_item              i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out_item             i_out_data,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_expect_cnt,
    output int                    o_err_cnt
);

    localparam int HIST_N = 4 * MAX_WIDTH + 8;

    logic [PIX_W-1:0] samples [HIST_N];
    int               newest;
    int               cols_reg;
    int               rows_reg;
    int               backlog;
    int               res_row;
    int               res_col;
    t_out_item        expected_px [$];

    function automatic int clamp_to(input int v, input int hi);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [PIX_W-1:0] sample_at(input int back);
        return samples[(newest + HIST_N - back) % HIST_N];
    endfunction

    function automatic logic [PIX_W-1:0] window_median(input int back, input int w);
        logic [PIX_W-1:0] win [WIN_SIZE];
        logic [PIX_W-1:0] v;
        int k;
        int j;
        k = 0;
        for (int dr = -2; dr <= 2; dr++) begin
            for (int dc = -2; dc <= 2; dc++) begin
                win[k] = sample_at(back - dr * w - dc);
                k++;
            end
        end
        for (int i = 1; i < WIN_SIZE; i++) begin
            v = win[i];
            j = i;
            while (j > 0 && win[j-1] > v) begin
                win[j] = win[j-1];
                j--;
            end
            win[j] = v;
        end
        return win[WIN_MID];
    endfunction

    function automatic bit is_edge(input int r, input int c, input int w, input int h);
        return r < 2 || c < 2 || r + 2 >= h || c + 2 >= w;
    endfunction

    // release the oldest pending pixel into the expected queue
    task automatic release_word(input int w, input int h);
        t_out_item px;
        px.pixel_out  = is_edge(res_row, res_col, w, h) ? sample_at(backlog - 1)
                                                         : window_median(backlog - 1, w);
        px.out_row    = COORD_W'(res_row);
        px.out_col    = COORD_W'(res_col);
        px.frame_last = (res_row + 1 == h) && (res_col + 1 == w);
        expected_px.push_back(px);
        res_col++;
        if (res_col >= w) begin
            res_col = 0;
            res_row = (res_row + 1 >= h) ? 0 : res_row + 1;
        end
        backlog--;
    endtask

    task automatic median_predict(input t_in_item it);
        int w;
        int h;
        w = clamp_to(cols_reg, MAX_WIDTH);
        h = clamp_to(rows_reg, MAX_HEIGHT);
        if (it.operation == OP_PIXEL) begin
            newest = (newest + 1) % HIST_N;
            samples[newest] = it.pixel_in;
            backlog++;
            if (backlog > 2 * w + 2) release_word(w, h);
        end else if (backlog > 0 && is_edge(res_row, res_col, w, h)) begin
            release_word(w, h);
        end
    endtask

    initial begin
        for (int i = 0; i < HIST_N; i++) samples[i] = '0;
        newest = 0;
        o_err_cnt = 0;
        o_expect_cnt = 0;
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            cols_reg = MAX_WIDTH;
            rows_reg = MAX_HEIGHT;
            backlog = 0;
            res_row = 0;
            res_col = 0;
            expected_px.delete();
        end else begin
            if (i_cfg_wr_en && (i_cfg_idx == CFG_WIDTH || i_cfg_idx == CFG_HEIGHT)) begin
                if (i_cfg_idx == CFG_WIDTH) cols_reg = i_cfg_data;
                else rows_reg = i_cfg_data;
                backlog = 0;
                res_row = 0;
                res_col = 0;
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_px.size() == 0) begin
                    $error("unexpected word: pixel_out %0d row %0d col %0d",
                           i_out_data.pixel_out, i_out_data.out_row, i_out_data.out_col);
                    o_err_cnt <= o_err_cnt + 1;
                end else begin
                    want = expected_px.pop_front();
                    if (want != i_out_data) o_err_cnt <= o_err_cnt + 1;
                    if (want.pixel_out != i_out_data.pixel_out)
                        $error("pixel_out: expected %0d, got %0d",
                               want.pixel_out, i_out_data.pixel_out);
                    if (want.out_row != i_out_data.out_row)
                        $error("out_row: expected %0d, got %0d",
                               want.out_row, i_out_data.out_row);
                    if (want.out_col != i_out_data.out_col)
                        $error("out_col: expected %0d, got %0d",
                               want.out_col, i_out_data.out_col);
                    if (want.frame_last != i_out_data.frame_last)
                        $error("frame_last: expected %0d, got %0d",
                               want.frame_last, i_out_data.frame_last);
                end
            end
            if (i_in_valid && !i_in_stall) median_predict(i_in_data);
        end
        o_expect_cnt <= expected_px.size();
    end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives frames, flushes and register writes into the 5x5 median filter with
// bursty input and a stalling receiver; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
    import mf5x5_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int LIMIT       = 600000;
    localparam int RAND_PIXELS = 1850;
    localparam int SETTLE      = 12;
    localparam int HOLD_CYC    = 400;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_item              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_item             o_out_data;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    expect_cnt;
    int                    err_cnt;
    int                    cyc;
    bit                    hold_req;
    bit                    no_gaps;
    int                    burst_left;

    median_filter_5x5 dut (.*);

    mf5x5_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall), .i_in_data(i_in_data),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall), .i_out_data(o_out_data),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_expect_cnt(expect_cnt), .o_err_cnt(err_cnt)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial cyc = 0;
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // receiver: a random stall mode is drawn for each run of stall decisions; one long hold on request
    initial begin
        int mode;
        i_out_stall = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            for (int i = 0; i < 64; i++) begin
                @(negedge i_clk);
                if (hold_req) begin
                    i_out_stall <= 1'b1;
                    for (int k = 1; k < HOLD_CYC; k++) @(negedge i_clk);
                    hold_req = 0;
                end else begin
                    case (mode)
                        0: i_out_stall <= 1'b0;
                        1: i_out_stall <= ($urandom_range(0, 99) < 30);
                        2: i_out_stall <= ($urandom_range(0, 99) < 75);
                        default: i_out_stall <= i[0];
                    endcase
                end
            end
        end
    end

    task automatic send_word(input t_op op, input logic [PIX_W-1:0] pix);
        int gap;
        if (!no_gaps && burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = $urandom_range(0, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                for (int g = 1; g < gap; g++) @(negedge i_clk);
            end
        end
        if (burst_left > 0) burst_left--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= '{operation: op, pixel_in: pix};
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain_wait();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expect_cnt != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_data  <= d;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [PIX_W-1:0] rand_pix();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return PIX_W'($urandom_range(100, 110));
            default: return PIX_W'($urandom);
        endcase
    endfunction

    function automatic int rand_dim();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 4);
            1: return $urandom_range(11, 40);
            default: return $urandom_range(5, 10);
        endcase
    endfunction

    initial begin
        int pix_sent;
        int phase;
        int w;
        int h;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_idx   = CFG_WIDTH;
        i_cfg_data  = '0;
        hold_req    = 0;
        no_gaps     = 0;
        burst_left  = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: undersized dims clamp to 5x5, flush with nothing pending
        write_reg(CFG_WIDTH, '0);
        write_reg(CFG_HEIGHT, '0);
        send_word(OP_FLUSH, 8'hA5);
        for (int i = 0; i < 25; i++) begin
            send_word(OP_PIXEL, (i % 3 == 0) ? 8'h00 : (i % 3 == 1) ? 8'hFF : PIX_W'(i * 9));
            // interior next: flush must be ignored
            if (i == 23) send_word(OP_FLUSH, '0);
        end
        for (int i = 0; i < 14; i++) send_word(OP_FLUSH, '1);
        drain_wait();

        // unknown index: stream and dims must not change
        write_reg(CFG_SPARE, 11'd7);
        for (int i = 0; i < 25; i++) send_word(OP_PIXEL, rand_pix());
        for (int i = 0; i < 12; i++) send_word(OP_FLUSH, '0);
        drain_wait();

        pix_sent = 0;
        phase = 0;
        while (pix_sent < RAND_PIXELS) begin
            w = rand_dim();
            h = rand_dim();
            write_reg(CFG_WIDTH, CFG_DATA_W'(w));
            write_reg(CFG_HEIGHT, CFG_DATA_W'(h));
            w = (w < MIN_DIM) ? MIN_DIM : w;
            h = (h < MIN_DIM) ? MIN_DIM : h;
            no_gaps = ($urandom_range(0, 3) == 0);
            if (phase == 1) hold_req = 1;
            repeat ($urandom_range(1, 3)) begin
                for (int p = 0; p < w * h; p++) begin
                    if ($urandom_range(0, 99) < 3) send_word(OP_FLUSH, PIX_W'($urandom));
                    send_word(OP_PIXEL, rand_pix());
                    pix_sent++;
                end
                if ($urandom_range(0, 9) < 6)
                    repeat (2 * w + 2 + $urandom_range(0, 3))
                        send_word(OP_FLUSH, PIX_W'($urandom));
            end
            // sender pauses until every released word has left
            drain_wait();
            phase++;
        end

        // oversized dims clamp to the maximum; short run on the widest line
        no_gaps = 0;
        write_reg(CFG_WIDTH, '1);
        write_reg(CFG_HEIGHT, '1);
        for (int i = 0; i < 2 * MAX_WIDTH + 8; i++) send_word(OP_PIXEL, rand_pix());
        for (int i = 0; i < 10; i++) send_word(OP_FLUSH, '0);
        drain_wait();
        write_reg(CFG_HEIGHT, CFG_DATA_W'(MAX_HEIGHT));
        write_reg(CFG_WIDTH, CFG_DATA_W'(MIN_DIM));
        for (int i = 0; i < 30; i++) send_word(OP_PIXEL, rand_pix());
        drain_wait();

        if (err_cnt == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
